// ===== rtl/urdd_pkg.sv =====
// Shared types, constants and helpers for the ultrasonic range / deadband drive unit.
// Used by every module in rtl/; depends on nothing else.
package urdd_pkg;

    localparam int TEMP_W     = 12;
    localparam int DIST_W     = 11;
    localparam int NEAR_W     = 11;
    localparam int THR_W      = 12;
    localparam int TIMEOUT_W  = 16;
    localparam int REST_W     = 24;
    localparam int TICK_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MOTOR_W    = 2;

    localparam int ADC_BITS_DEF = 12;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_PERIOD  = 3'd4;

    localparam logic [NEAR_W-1:0]    NEAR_LIMIT_RST   = 11'd20;
    localparam logic [NEAR_W-1:0]    FAR_LIMIT_RST    = 11'd40;
    localparam logic [THR_W-1:0]     FAN_THRESH_RST   = 12'd245;
    localparam logic [TIMEOUT_W-1:0] ECHO_TIMEOUT_RST = 16'd30000;
    localparam logic [REST_W-1:0]    REST_PERIOD_RST  = 24'd500000;

    localparam logic [MOTOR_W-1:0] MOTOR_STOP = 2'd0;
    localparam logic [MOTOR_W-1:0] MOTOR_FWD  = 2'd1;
    localparam logic [MOTOR_W-1:0] MOTOR_BACK = 2'd2;

    localparam logic [DIST_W-1:0] TIMEOUT_DIST = 11'd255;
    localparam logic [DIST_W-1:0] DIST_MAX     = 11'd1129;

    // 1/58 as 2^22-scaled reciprocal, exact for every 16-bit width
    localparam int                DIV58_SHIFT = 22;
    localparam logic [16:0]       DIV58_MULT  = 17'd72316;

    typedef struct packed {
        logic              echo_level;
        logic [TEMP_W-1:0] temp_code;
    } in_item_t;

    typedef struct packed {
        logic               trigger_out;
        logic [MOTOR_W-1:0] motor_cmd;
        logic               fan_on;
        logic [DIST_W-1:0]  distance_cm;
        logic               distance_valid;
    } out_item_t;

    // measurement completion from the sequencer to the drive logic
    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] dist_cm;
    } seq_evt_t;

    function automatic logic [DIST_W-1:0] div58(input logic [TIMEOUT_W-1:0] x);
        logic [TIMEOUT_W+17-1:0] prod;
        prod = x * DIV58_MULT;
        return prod[DIV58_SHIFT +: DIST_W];
    endfunction

endpackage

// ===== rtl/ultrasonic_range_deadband_drive_unit.sv =====
// Top level of the ultrasonic range / deadband drive unit.
// Depends on urdd_pkg, urdd_seq and urdd_drive.
//
// Each item on the s_ channel is one microsecond tick and produces exactly one item on the m_
// channel. An item is taken into an input register, evaluated by the sequencer and the drive
// logic, and lands in the output register: one item per clock sustained while m_ready is
// high, m_valid rising as it enters the output register. The pipeline advances whenever
// the output register is empty or being taken, so s_ready follows m_ready through one gate.
// Configuration writes take effect on the next item evaluated and are meant for idle periods.
module ultrasonic_range_deadband_drive_unit #(
    parameter int ADC_BITS = urdd_pkg::ADC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  urdd_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output urdd_pkg::out_item_t                 m_data,
    input  logic                                cfg_we,
    input  logic [urdd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [urdd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [urdd_pkg::NEAR_W-1:0]    near_reg;
    logic [urdd_pkg::NEAR_W-1:0]    far_reg;
    logic [urdd_pkg::THR_W-1:0]     thresh_reg;
    logic [urdd_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [urdd_pkg::REST_W-1:0]    rest_reg;

    logic                 in_valid_reg, in_valid_next;
    urdd_pkg::in_item_t   in_data_reg;
    logic                 out_valid_reg, out_valid_next;
    urdd_pkg::out_item_t  out_data_reg, out_data_next;

    logic                 advance;
    logic                 step;
    logic                 trig;
    urdd_pkg::seq_evt_t   evt;
    logic [urdd_pkg::MOTOR_W-1:0] motor_next;
    logic                 fan_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg    <= urdd_pkg::NEAR_LIMIT_RST;
            far_reg     <= urdd_pkg::FAR_LIMIT_RST;
            thresh_reg  <= urdd_pkg::FAN_THRESH_RST;
            timeout_reg <= urdd_pkg::ECHO_TIMEOUT_RST;
            rest_reg    <= urdd_pkg::REST_PERIOD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                urdd_pkg::CFG_NEAR_LIMIT:   near_reg    <= cfg_wdata[urdd_pkg::NEAR_W-1:0];
                urdd_pkg::CFG_FAR_LIMIT:    far_reg     <= cfg_wdata[urdd_pkg::NEAR_W-1:0];
                urdd_pkg::CFG_FAN_THRESH:   thresh_reg  <= cfg_wdata[urdd_pkg::THR_W-1:0];
                urdd_pkg::CFG_ECHO_TIMEOUT: timeout_reg <= cfg_wdata[urdd_pkg::TIMEOUT_W-1:0];
                urdd_pkg::CFG_REST_PERIOD:  rest_reg    <= cfg_wdata[urdd_pkg::REST_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign step    = in_valid_reg && advance;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    urdd_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .echo_level   (in_data_reg.echo_level),
        .echo_timeout (timeout_reg),
        .rest_period  (rest_reg),
        .trigger_out  (trig),
        .evt          (evt)
    );

    urdd_drive #(
        .ADC_BITS (ADC_BITS)
    ) u_drive (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .evt        (evt),
        .temp_code  (in_data_reg.temp_code),
        .near_limit (near_reg),
        .far_limit  (far_reg),
        .fan_thresh (thresh_reg),
        .motor_next (motor_next),
        .fan_next   (fan_next)
    );

    always_comb begin
        out_data_next.trigger_out    = trig;
        out_data_next.motor_cmd      = motor_next;
        out_data_next.fan_on         = fan_next;
        out_data_next.distance_cm    = evt.dist_cm;
        out_data_next.distance_valid = evt.done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // a stalled item in the input register is never dropped
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input item lost while stalled");

    // distance is zero unless a measurement completes
    a_dist_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.distance_valid |-> m_data.distance_cm == '0)
        else $error("distance without completion");

    // completion never falls in a trigger pulse, and distance stays in range
    a_done_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.distance_valid |->
            !m_data.trigger_out && m_data.distance_cm <= urdd_pkg::DIST_MAX)
        else $error("bad completion item");

endmodule

// ===== rtl/urdd_seq.sv =====
// Trigger / echo timing sequencer: phase state and tick counter.
// Depends on urdd_pkg.
module urdd_seq (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step,
    input  logic                               echo_level,
    input  logic [urdd_pkg::TIMEOUT_W-1:0]     echo_timeout,
    input  logic [urdd_pkg::REST_W-1:0]        rest_period,
    output logic                               trigger_out,
    output urdd_pkg::seq_evt_t                 evt
);

    localparam logic [2:0] PH_TRIG_LOW  = 3'd0;
    localparam logic [2:0] PH_TRIG_HIGH = 3'd1;
    localparam logic [2:0] PH_WAIT_RISE = 3'd2;
    localparam logic [2:0] PH_TIME_HIGH = 3'd3;
    localparam logic [2:0] PH_REST      = 3'd4;

    localparam int CNT_W = urdd_pkg::TICK_W + 1;
    localparam logic [CNT_W-1:0] TRIG_LOW_TICKS  = 25'd2;
    localparam logic [CNT_W-1:0] TRIG_HIGH_TICKS = 25'd10;

    logic [2:0]                  phase_reg, phase_next;
    logic [urdd_pkg::TICK_W-1:0] ticks_reg, ticks_next;
    logic [CNT_W-1:0]            inc;
    logic [CNT_W-1:0]            timeout_x;
    logic [CNT_W-1:0]            rest_x;

    always_comb begin
        inc         = {1'b0, ticks_reg} + 25'd1;
        timeout_x   = CNT_W'(echo_timeout);
        rest_x      = CNT_W'(rest_period);
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        trigger_out = 1'b0;
        evt.done    = 1'b0;
        evt.dist_cm = '0;
        case (phase_reg)
            PH_TRIG_LOW: begin
                ticks_next = inc[urdd_pkg::TICK_W-1:0];
                if (inc >= TRIG_LOW_TICKS) begin
                    phase_next = PH_TRIG_HIGH;
                    ticks_next = '0;
                end
            end
            PH_TRIG_HIGH: begin
                trigger_out = 1'b1;
                ticks_next  = inc[urdd_pkg::TICK_W-1:0];
                if (inc >= TRIG_HIGH_TICKS) begin
                    phase_next = PH_WAIT_RISE;
                    ticks_next = '0;
                end
            end
            PH_WAIT_RISE: begin
                if (echo_level) begin
                    // rising tick counts as the first high tick
                    phase_next = PH_TIME_HIGH;
                    ticks_next = 24'd1;
                    if (echo_timeout == '0) begin
                        evt.done    = 1'b1;
                        evt.dist_cm = urdd_pkg::TIMEOUT_DIST;
                    end
                end else if (inc > timeout_x) begin
                    evt.done    = 1'b1;
                    evt.dist_cm = urdd_pkg::TIMEOUT_DIST;
                end else begin
                    ticks_next = inc[urdd_pkg::TICK_W-1:0];
                end
            end
            PH_TIME_HIGH: begin
                if (echo_level) begin
                    if (inc > timeout_x) begin
                        evt.done    = 1'b1;
                        evt.dist_cm = urdd_pkg::TIMEOUT_DIST;
                    end else begin
                        ticks_next = inc[urdd_pkg::TICK_W-1:0];
                    end
                end else begin
                    // width never exceeds the 16-bit timeout here
                    evt.done    = 1'b1;
                    evt.dist_cm = urdd_pkg::div58(ticks_reg[urdd_pkg::TIMEOUT_W-1:0]);
                end
            end
            PH_REST: begin
                ticks_next = inc[urdd_pkg::TICK_W-1:0];
                if (inc >= rest_x) begin
                    phase_next = PH_TRIG_LOW;
                    ticks_next = '0;
                end
            end
            default: begin
                phase_next = PH_TRIG_LOW;
                ticks_next = '0;
            end
        endcase
        if (evt.done) begin
            phase_next = (rest_period != '0) ? PH_REST : PH_TRIG_LOW;
            ticks_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TRIG_LOW;
            ticks_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

// ===== rtl/urdd_drive.sv =====
// Motor deadband decision and fan switch, with their held states.
// Depends on urdd_pkg.
module urdd_drive #(
    parameter int ADC_BITS = urdd_pkg::ADC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  urdd_pkg::seq_evt_t                evt,
    input  logic [urdd_pkg::TEMP_W-1:0]       temp_code,
    input  logic [urdd_pkg::NEAR_W-1:0]       near_limit,
    input  logic [urdd_pkg::NEAR_W-1:0]       far_limit,
    input  logic [urdd_pkg::THR_W-1:0]        fan_thresh,
    output logic [urdd_pkg::MOTOR_W-1:0]      motor_next,
    output logic                              fan_next
);

    logic [urdd_pkg::MOTOR_W-1:0] motor_reg;
    logic                         fan_reg;
    logic [urdd_pkg::TEMP_W-1:0]  temp_m;

    // only the low ADC_BITS bits of the code are significant
    always_comb begin
        for (int i = 0; i < urdd_pkg::TEMP_W; i++) begin
            temp_m[i] = temp_code[i] & (i < ADC_BITS);
        end
    end

    always_comb begin
        motor_next = motor_reg;
        fan_next   = fan_reg;
        if (evt.done) begin
            if (evt.dist_cm < near_limit) begin
                motor_next = urdd_pkg::MOTOR_BACK;
            end else if (evt.dist_cm > far_limit) begin
                motor_next = urdd_pkg::MOTOR_FWD;
            end else begin
                motor_next = urdd_pkg::MOTOR_STOP;
            end
            fan_next = (temp_m > fan_thresh);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motor_reg <= urdd_pkg::MOTOR_STOP;
            fan_reg   <= 1'b0;
        end else if (step) begin
            motor_reg <= motor_next;
            fan_reg   <= fan_next;
        end
    end

endmodule
